FILE: design/swfb_pkg.sv
// Shared types and constants of the stop-and-wait frame builder.
`timescale 1ns / 1ps
`default_nettype none

package swfb_pkg;

  // Operation codes of an input item
  localparam logic OP_PAYLOAD = 1'b0;
  localparam logic OP_REPLY   = 1'b1;

  // Reply codes
  localparam logic [2:0] REPLY_RR0  = 3'd0;
  localparam logic [2:0] REPLY_RR1  = 3'd1;
  localparam logic [2:0] REPLY_REJ0 = 3'd2;
  localparam logic [2:0] REPLY_REJ1 = 3'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_FLAG      = 3'd0;
  localparam logic [2:0] REG_ESCAPE    = 3'd1;
  localparam logic [2:0] REG_ESC_FLAG  = 3'd2;
  localparam logic [2:0] REG_ESC_ESC   = 3'd3;
  localparam logic [2:0] REG_ADDRESS   = 3'd4;
  localparam logic [2:0] REG_CTRL_ZERO = 3'd5;
  localparam logic [2:0] REG_CTRL_ONE  = 3'd6;

  localparam int ADDR_W  = 5;
  localparam int QUEUE_D = 2;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] escaped_flag_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] address_value;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // One classified item, as handed from the front to the back
  typedef struct packed {
    logic       is_reply;
    logic       open;
    logic       last;
    logic [7:0] data;
    logic [7:0] ctrl;
    logic [7:0] check;
    logic [1:0] kind;
  } job_t;

endpackage

`default_nettype wire

FILE: design/swfb_cfg.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none

module swfb_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [swfb_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output      logic [31:0]                cfg_prdata,
  output      logic                       cfg_pready,
  output      swfb_pkg::cfg_t             cfg
);

  swfb_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;
  logic [7:0]     rd_byte;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        swfb_pkg::REG_FLAG:      cfg_nxt.flag_value          = cfg_pwdata[7:0];
        swfb_pkg::REG_ESCAPE:    cfg_nxt.escape_value        = cfg_pwdata[7:0];
        swfb_pkg::REG_ESC_FLAG:  cfg_nxt.escaped_flag_code   = cfg_pwdata[7:0];
        swfb_pkg::REG_ESC_ESC:   cfg_nxt.escaped_escape_code = cfg_pwdata[7:0];
        swfb_pkg::REG_ADDRESS:   cfg_nxt.address_value       = cfg_pwdata[7:0];
        swfb_pkg::REG_CTRL_ZERO: cfg_nxt.control_seq_zero    = cfg_pwdata[7:0];
        swfb_pkg::REG_CTRL_ONE:  cfg_nxt.control_seq_one     = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swfb_pkg::REG_FLAG:      rd_byte = cfg_r.flag_value;
      swfb_pkg::REG_ESCAPE:    rd_byte = cfg_r.escape_value;
      swfb_pkg::REG_ESC_FLAG:  rd_byte = cfg_r.escaped_flag_code;
      swfb_pkg::REG_ESC_ESC:   rd_byte = cfg_r.escaped_escape_code;
      swfb_pkg::REG_ADDRESS:   rd_byte = cfg_r.address_value;
      swfb_pkg::REG_CTRL_ZERO: rd_byte = cfg_r.control_seq_zero;
      swfb_pkg::REG_CTRL_ONE:  rd_byte = cfg_r.control_seq_one;
      default:                 rd_byte = 8'd0;
    endcase
  end

  assign cfg_prdata = {24'd0, rd_byte};
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value          <= 8'd126;
      cfg_r.escape_value        <= 8'd125;
      cfg_r.escaped_flag_code   <= 8'd94;
      cfg_r.escaped_escape_code <= 8'd93;
      cfg_r.address_value       <= 8'd3;
      cfg_r.control_seq_zero    <= 8'd0;
      cfg_r.control_seq_one     <= 8'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/swfb_front.sv
// Front end: accepts items, keeps frame and sequence state, classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module swfb_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  swfb_pkg::cfg_t      cfg,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire logic           in_operation,
  input  wire logic [7:0]     in_payload_byte,
  input  wire logic           in_end_of_payload,
  input  wire logic [2:0]     in_reply_kind,
  input  wire logic           q_full,
  output      logic           q_push,
  output      swfb_pkg::job_t q_job
);

  logic       inside_frame_r, inside_frame_nxt;
  logic       seq_bit_r, seq_bit_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] xor_new;
  logic       opening;

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  assign opening = !inside_frame_r;
  assign xor_new = (opening ? 8'd0 : xor_r) ^ in_payload_byte;

  always_comb begin
    q_job            = '0;
    inside_frame_nxt = inside_frame_r;
    seq_bit_nxt      = seq_bit_r;
    xor_nxt          = xor_r;

    q_job.is_reply = (in_operation == swfb_pkg::OP_REPLY);
    q_job.open     = opening;
    q_job.last     = in_end_of_payload;
    q_job.data     = in_payload_byte;
    q_job.ctrl     = seq_bit_r ? cfg.control_seq_one : cfg.control_seq_zero;
    q_job.check    = xor_new;
    q_job.kind     = swfb_pkg::KIND_INVALID;

    if (in_operation == swfb_pkg::OP_PAYLOAD) begin
      inside_frame_nxt = !in_end_of_payload;
      xor_nxt          = in_end_of_payload ? 8'd0 : xor_new;
    end else if (!inside_frame_r) begin
      case (in_reply_kind)
        swfb_pkg::REPLY_RR0: begin
          if (seq_bit_r) begin
            q_job.kind  = swfb_pkg::KIND_ACK;
            seq_bit_nxt = 1'b0;
          end
        end
        swfb_pkg::REPLY_RR1: begin
          if (!seq_bit_r) begin
            q_job.kind  = swfb_pkg::KIND_ACK;
            seq_bit_nxt = 1'b1;
          end
        end
        swfb_pkg::REPLY_REJ0, swfb_pkg::REPLY_REJ1: q_job.kind = swfb_pkg::KIND_REJECT;
        default: q_job.kind = swfb_pkg::KIND_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
      seq_bit_r      <= 1'b0;
      xor_r          <= 8'd0;
    end else if (q_push) begin
      inside_frame_r <= inside_frame_nxt;
      seq_bit_r      <= seq_bit_nxt;
      xor_r          <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/swfb_queue.sv
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module swfb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  swfb_pkg::job_t      push_job,
  input  wire logic           pop,
  output      swfb_pkg::job_t pop_job,
  output      logic           empty,
  output      logic           full
);

  swfb_pkg::job_t entry_r [swfb_pkg::QUEUE_D];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'(swfb_pkg::QUEUE_D));
  assign pop_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/swfb_back.sv
// Back end: steps through the bytes of each queued item into the output register.
`timescale 1ns / 1ps
`default_nettype none

module swfb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  swfb_pkg::cfg_t      cfg,
  input  wire logic           q_empty,
  input  swfb_pkg::job_t      q_job,
  output      logic           q_pop,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic [7:0]     out_line_byte,
  output      logic [1:0]     out_kind,
  output      logic           out_last_of_run
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_FLAG  = 11'b000_0000_0010,
    ST_ADDR  = 11'b000_0000_0100,
    ST_CTRL  = 11'b000_0000_1000,
    ST_HCHK  = 11'b000_0001_0000,
    ST_DATA  = 11'b000_0010_0000,
    ST_DATA2 = 11'b000_0100_0000,
    ST_CHK   = 11'b000_1000_0000,
    ST_CHK2  = 11'b001_0000_0000,
    ST_CLOSE = 11'b010_0000_0000,
    ST_REPLY = 11'b100_0000_0000
  } step_t;

  step_t          step_r, step_nxt, step_adv, step_start;
  swfb_pkg::job_t job_r, job_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     byte_r, byte_nxt, byte_c;
  logic [1:0]     kind_r, kind_nxt, kind_c;
  logic           last_r, last_nxt;
  logic           done_c;
  logic           out_free;
  logic           emit;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (step_r != ST_IDLE) && out_free;

  // Byte for the current step, and where the step goes next
  always_comb begin
    byte_c   = 8'd0;
    kind_c   = swfb_pkg::KIND_BYTE;
    done_c   = 1'b0;
    step_adv = step_r;
    case (step_r)
      ST_FLAG: begin
        byte_c   = cfg.flag_value;
        step_adv = ST_ADDR;
      end
      ST_ADDR: begin
        byte_c   = cfg.address_value;
        step_adv = ST_CTRL;
      end
      ST_CTRL: begin
        byte_c   = job_r.ctrl;
        step_adv = ST_HCHK;
      end
      ST_HCHK: begin
        byte_c   = cfg.address_value ^ job_r.ctrl;
        step_adv = ST_DATA;
      end
      ST_DATA: begin
        if (job_r.data == cfg.flag_value || job_r.data == cfg.escape_value) begin
          byte_c   = cfg.escape_value;
          step_adv = ST_DATA2;
        end else begin
          byte_c   = job_r.data;
          step_adv = ST_CHK;
          done_c   = !job_r.last;
        end
      end
      ST_DATA2: begin
        // flag wins when flag and escape are the same byte
        byte_c   = (job_r.data == cfg.flag_value) ? cfg.escaped_flag_code
                                                  : cfg.escaped_escape_code;
        step_adv = ST_CHK;
        done_c   = !job_r.last;
      end
      ST_CHK: begin
        if (job_r.check == cfg.flag_value || job_r.check == cfg.escape_value) begin
          byte_c   = cfg.escape_value;
          step_adv = ST_CHK2;
        end else begin
          byte_c   = job_r.check;
          step_adv = ST_CLOSE;
        end
      end
      ST_CHK2: begin
        byte_c   = (job_r.check == cfg.flag_value) ? cfg.escaped_flag_code
                                                   : cfg.escaped_escape_code;
        step_adv = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_c = cfg.flag_value;
        done_c = 1'b1;
      end
      ST_REPLY: begin
        kind_c = job_r.kind;
        done_c = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (q_job.is_reply) begin
      step_start = ST_REPLY;
    end else if (q_job.open) begin
      step_start = ST_FLAG;
    end else begin
      step_start = ST_DATA;
    end
  end

  // Take the next item as soon as the current one has issued its last byte
  assign q_pop = !q_empty && ((step_r == ST_IDLE) || (emit && done_c));

  always_comb begin
    job_nxt = q_pop ? q_job : job_r;
    if (emit && !done_c) begin
      step_nxt = step_adv;
    end else if (q_pop) begin
      step_nxt = step_start;
    end else if (emit) begin
      step_nxt = ST_IDLE;
    end else begin
      step_nxt = step_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = byte_c;
      kind_nxt      = kind_c;
      last_nxt      = done_c;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_byte   = byte_r;
  assign out_kind        = kind_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire

FILE: design/stop_and_wait_frame_builder_top.sv
// Top level of the stop-and-wait frame builder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    operation, payload_byte, end_of_payload, reply_kind
//   out_     output     out_valid/out_stall  line_byte, kind, last_of_run
//   cfg_     input      APB write/read       seven 8-bit registers at 4*index
//
// The back end issues one result per cycle while out_stall is low: a payload byte
// yields header, stuffing, check and closing flag bytes as needed, a reply one result.
// The front end takes an item per cycle while the two-entry queue has room.
// Reset restores the registers and clears frame, sequence and check state.
// out_stall holds the output register; the queue lets the front keep accepting.
`timescale 1ns / 1ps
`default_nettype none

module stop_and_wait_frame_builder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_operation,
  input  wire logic [7:0]                  in_payload_byte,
  input  wire logic                        in_end_of_payload,
  input  wire logic [2:0]                  in_reply_kind,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [7:0]                  out_line_byte,
  output      logic [1:0]                  out_kind,
  output      logic                        out_last_of_run,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [swfb_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output      logic [31:0]                 cfg_prdata,
  output      logic                        cfg_pready
);

  swfb_pkg::cfg_t cfg;
  swfb_pkg::job_t push_job, pop_job;
  logic           q_push, q_pop, q_empty, q_full;

  swfb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  swfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_payload_byte   (in_payload_byte),
    .in_end_of_payload (in_end_of_payload),
    .in_reply_kind     (in_reply_kind),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (push_job)
  );

  swfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  swfb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_byte   (out_line_byte),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
